// ----- rtl/kts_pkg.sv -----
// shared constants, controller states and command/status structs of the topological sort engine
`timescale 1ns / 1ps
package kts_pkg;

  // field widths fixed by the stream format
  localparam int NodeW       = 5;
  localparam int CfgW        = 6;
  localparam int FieldLimit  = 32;
  localparam int InDataW     = 16;
  localparam int OutDataW    = 8;
  localparam int OutUserW    = 3;

  // defaults for the top level parameters
  localparam int DefMaxNodes = 32;
  localparam int DefMaxEdges = 256;

  // node count after reset
  localparam logic [CfgW-1:0] NodeCountReset = 6'd32;

  // input kinds carried in tuser
  localparam logic OpAddEdge = 1'b0;
  localparam logic OpRunSort = 1'b1;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_CNT_RD,
    S_CNT_CHK,
    S_CNT_UPD,
    S_SEED_RD,
    S_SEED_CHK,
    S_POP,
    S_EMIT,
    S_SCN_RD,
    S_SCN_CHK,
    S_SCN_UPD,
    S_FINISH
  } kts_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic edge_load;
    logic i_clr;
    logic i_inc;
    logic e_clr;
    logic e_inc;
    logic q_clr;
    logic edge_rd;
    logic deg_rd_dst;
    logic deg_rd_idx;
    logic deg_wr_zero;
    logic deg_wr_inc;
    logic deg_wr_dec;
    logic push_idx;
    logic push_dst;
    logic fifo_rd;
    logic out_node;
    logic out_cycle;
    logic run_done;
  } kts_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic i_at_n;
    logic e_at_total;
    logic edge_keep;
    logic edge_match;
    logic deg_zero;
    logic deg_one;
    logic fifo_empty;
    logic all_emitted;
    logic out_free;
  } kts_sts_t;

endpackage

// ----- rtl/kahn_topological_sort_top.sv -----
// Edge add: transactions are accepted back to back while idle.
// Run: clears the in-degree table, recounts in-degrees over the stored edges, seeds the queue,
// then per emitted node scans every stored edge, then finishes; result stalls hold the run up
// and the next transaction is taken once the run has finished.
// Reset (rst_ni low, asynchronous) empties the edge store, clears the drop flag and the
// result valid flag and sets node_count to 32; no clearing pass is needed.
`timescale 1ns / 1ps
module kahn_topological_sort_top
  import kts_pkg::*;
#(
  parameter int MAX_NODES = DefMaxNodes,
  parameter int MAX_EDGES = DefMaxEdges
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // node count register write
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgW-1:0]     cfg_data_i,
  // input transactions
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // src_node[4:0], dst_node[9:5], zero fill
  input  logic                s_axis_tuser,  // op
  // result transactions
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // order_node[4:0], zero fill
  output logic [OutUserW-1:0] m_axis_tuser,  // node_valid[0], cycle_found[1], edge_dropped[2]
  output logic                m_axis_tlast
);

  kts_cmd_t cmd;
  kts_sts_t sts;

  // sequencer
  kts_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // storage and result register
  kts_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

// ----- rtl/kts_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
module kts_ram #(
  parameter  int Width = 8,
  parameter  int Depth = 32,
  localparam int Aw    = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, data held between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/kts_ctrl.sv -----
// sequencer of the topological sort: edge loading, in-degree recount, seeding and node scans
`timescale 1ns / 1ps
module kts_ctrl
  import kts_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_axis_tvalid,
  input  logic     s_axis_tuser,
  output logic     s_axis_tready,
  input  kts_sts_t sts_i,
  output kts_cmd_t cmd_o
);

  kts_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (s_axis_tuser == OpRunSort) begin
            cmd_o.i_clr = 1'b1;
            state_d     = S_CLR;
          end else begin
            cmd_o.edge_load = 1'b1;
          end
        end
      end
      // zero the in-degree table
      S_CLR: begin
        if (sts_i.i_at_n) begin
          cmd_o.e_clr = 1'b1;
          state_d     = S_CNT_RD;
        end else begin
          cmd_o.deg_wr_zero = 1'b1;
          cmd_o.i_inc       = 1'b1;
        end
      end
      // recount in-degrees over the stored edges
      S_CNT_RD: begin
        if (sts_i.e_at_total) begin
          cmd_o.i_clr = 1'b1;
          cmd_o.q_clr = 1'b1;
          state_d     = S_SEED_RD;
        end else begin
          cmd_o.edge_rd = 1'b1;
          state_d       = S_CNT_CHK;
        end
      end
      S_CNT_CHK: begin
        if (sts_i.edge_keep) begin
          cmd_o.deg_rd_dst = 1'b1;
          state_d          = S_CNT_UPD;
        end else begin
          cmd_o.e_inc = 1'b1;
          state_d     = S_CNT_RD;
        end
      end
      S_CNT_UPD: begin
        cmd_o.deg_wr_inc = 1'b1;
        cmd_o.e_inc      = 1'b1;
        state_d          = S_CNT_RD;
      end
      // queue every node of in-degree zero in index order
      S_SEED_RD: begin
        if (sts_i.i_at_n) begin
          state_d = S_POP;
        end else begin
          cmd_o.deg_rd_idx = 1'b1;
          state_d          = S_SEED_CHK;
        end
      end
      S_SEED_CHK: begin
        cmd_o.push_idx = sts_i.deg_zero;
        cmd_o.i_inc    = 1'b1;
        state_d        = S_SEED_RD;
      end
      // take the next ready node
      S_POP: begin
        if (sts_i.fifo_empty) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.fifo_rd = 1'b1;
          state_d       = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_node = 1'b1;
          cmd_o.e_clr    = 1'b1;
          state_d        = S_SCN_RD;
        end
      end
      // walk the edges leaving the emitted node
      S_SCN_RD: begin
        if (sts_i.e_at_total) begin
          state_d = S_POP;
        end else begin
          cmd_o.edge_rd = 1'b1;
          state_d       = S_SCN_CHK;
        end
      end
      S_SCN_CHK: begin
        if (sts_i.edge_match) begin
          cmd_o.deg_rd_dst = 1'b1;
          state_d          = S_SCN_UPD;
        end else begin
          cmd_o.e_inc = 1'b1;
          state_d     = S_SCN_RD;
        end
      end
      S_SCN_UPD: begin
        cmd_o.deg_wr_dec = !sts_i.deg_zero;
        cmd_o.push_dst   = sts_i.deg_one;
        cmd_o.e_inc      = 1'b1;
        state_d          = S_SCN_RD;
      end
      // cycle marker when nodes are left, then clear the store
      S_FINISH: begin
        if (sts_i.all_emitted) begin
          cmd_o.run_done = 1'b1;
          state_d        = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.out_cycle = 1'b1;
          cmd_o.run_done  = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // only a run transaction leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !(s_axis_tvalid && s_axis_tuser == OpRunSort)) |=> state_q == S_IDLE)
    else $error("controller left idle without a run transaction");

  // a queue read is always followed by an emit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fifo_rd |=> state_q == S_EMIT)
    else $error("queue read not followed by emit");

  // a run ends only from the finish state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.run_done |-> state_q == S_FINISH)
    else $error("run closed outside the finish state");

endmodule

// ----- rtl/kts_dp.sv -----
// datapath of the topological sort: edge store, in-degree table, ready queue and result register
`timescale 1ns / 1ps
module kts_dp
  import kts_pkg::*;
#(
  parameter int MAX_NODES = DefMaxNodes,
  parameter int MAX_EDGES = DefMaxEdges
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic [OutUserW-1:0] m_axis_tuser,
  output logic                m_axis_tlast,
  input  kts_cmd_t            cmd_i,
  output kts_sts_t            sts_o
);

  localparam int NodeDepth = (MAX_NODES < FieldLimit) ? MAX_NODES : FieldLimit;
  localparam int NodeAw    = $clog2(NodeDepth);
  localparam int NcW       = $clog2(NodeDepth + 1);
  localparam int EcW       = $clog2(MAX_EDGES + 1);
  localparam int EaW       = $clog2(MAX_EDGES);
  localparam int DegW      = EcW;
  localparam int EdgeW     = 2 * NodeW;

  logic [CfgW-1:0]  node_count_q;
  logic [CfgW-1:0]  n6;
  logic [NcW-1:0]   n;
  logic [EcW-1:0]   edge_total_q, e_q;
  logic             drop_q;
  logic [NcW-1:0]   i_q, head_q, tail_q;
  logic [NodeW-1:0] in_src, in_dst;
  logic             add_keep;
  logic [EdgeW-1:0] edge_rdata;
  logic [NodeW-1:0] e_src, e_dst;
  logic [DegW-1:0]  deg_rdata, deg_wdata;
  logic             deg_we, deg_re;
  logic [NodeAw-1:0] deg_waddr, deg_raddr;
  logic [NodeW-1:0] fifo_rdata, fifo_wdata;
  logic             fifo_we;
  logic             out_load;
  logic             out_valid_q;
  logic [NodeW-1:0] out_node_q;
  logic             out_nvalid_q, out_cycle_q, out_drop_q, out_last_q;

  // node count register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NodeCountReset;
    end else if (cfg_valid_i) begin
      node_count_q <= cfg_data_i;
    end
  end

  // effective node count, limited to 1..NodeDepth
  always_comb begin
    if (node_count_q == '0) begin
      n6 = CfgW'(1);
    end else if (node_count_q > CfgW'(NodeDepth)) begin
      n6 = CfgW'(NodeDepth);
    end else begin
      n6 = node_count_q;
    end
  end
  assign n = n6[NcW-1:0];

  // incoming edge check
  assign in_src   = s_axis_tdata[NodeW-1:0];
  assign in_dst   = s_axis_tdata[EdgeW-1:NodeW];
  assign add_keep = ({1'b0, in_src} < n6) && ({1'b0, in_dst} < n6)
                    && (edge_total_q != EcW'(MAX_EDGES));

  // edge count and drop flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_total_q <= '0;
      drop_q       <= 1'b0;
    end else if (cmd_i.run_done) begin
      edge_total_q <= '0;
      drop_q       <= 1'b0;
    end else if (cmd_i.edge_load) begin
      if (add_keep) begin
        edge_total_q <= edge_total_q + EcW'(1);
      end else begin
        drop_q <= 1'b1;
      end
    end
  end

  // edge store, source in the upper half
  kts_ram #(
    .Width (EdgeW),
    .Depth (MAX_EDGES)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.edge_load && add_keep),
    .waddr_i (edge_total_q[EaW-1:0]),
    .wdata_i ({in_src, in_dst}),
    .re_i    (cmd_i.edge_rd),
    .raddr_i (e_q[EaW-1:0]),
    .rdata_o (edge_rdata)
  );

  assign e_src = edge_rdata[EdgeW-1:NodeW];
  assign e_dst = edge_rdata[NodeW-1:0];

  // loop counters and queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_q    <= '0;
      i_q    <= '0;
      head_q <= '0;
      tail_q <= '0;
    end else begin
      if (cmd_i.e_clr) begin
        e_q <= '0;
      end else if (cmd_i.e_inc) begin
        e_q <= e_q + EcW'(1);
      end
      if (cmd_i.i_clr) begin
        i_q <= '0;
      end else if (cmd_i.i_inc) begin
        i_q <= i_q + NcW'(1);
      end
      if (cmd_i.q_clr) begin
        head_q <= '0;
        tail_q <= '0;
      end else begin
        if (cmd_i.fifo_rd) begin
          head_q <= head_q + NcW'(1);
        end
        if (fifo_we) begin
          tail_q <= tail_q + NcW'(1);
        end
      end
    end
  end

  // in-degree table port selection
  always_comb begin
    deg_we    = cmd_i.deg_wr_zero || cmd_i.deg_wr_inc || cmd_i.deg_wr_dec;
    deg_re    = cmd_i.deg_rd_dst || cmd_i.deg_rd_idx;
    deg_raddr = cmd_i.deg_rd_idx ? i_q[NodeAw-1:0] : e_dst[NodeAw-1:0];
    deg_waddr = cmd_i.deg_wr_zero ? i_q[NodeAw-1:0] : e_dst[NodeAw-1:0];
    if (cmd_i.deg_wr_inc) begin
      deg_wdata = deg_rdata + DegW'(1);
    end else if (cmd_i.deg_wr_dec) begin
      deg_wdata = deg_rdata - DegW'(1);
    end else begin
      deg_wdata = '0;
    end
  end

  kts_ram #(
    .Width (DegW),
    .Depth (NodeDepth)
  ) u_deg_ram (
    .clk_i   (clk_i),
    .we_i    (deg_we),
    .waddr_i (deg_waddr),
    .wdata_i (deg_wdata),
    .re_i    (deg_re),
    .raddr_i (deg_raddr),
    .rdata_o (deg_rdata)
  );

  // ready queue of node indexes
  assign fifo_we    = cmd_i.push_idx || cmd_i.push_dst;
  assign fifo_wdata = cmd_i.push_idx ? NodeW'(i_q) : e_dst;

  kts_ram #(
    .Width (NodeW),
    .Depth (NodeDepth)
  ) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (tail_q[NodeAw-1:0]),
    .wdata_i (fifo_wdata),
    .re_i    (cmd_i.fifo_rd),
    .raddr_i (head_q[NodeAw-1:0]),
    .rdata_o (fifo_rdata)
  );

  // result register, the popped node stays on the queue read data
  assign out_load = cmd_i.out_node || cmd_i.out_cycle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_node_q   <= cmd_i.out_node ? fifo_rdata : '0;
      out_nvalid_q <= cmd_i.out_node;
      out_cycle_q  <= cmd_i.out_cycle;
      out_drop_q   <= drop_q;
      out_last_q   <= cmd_i.out_cycle || (head_q == n);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_node_q);
  assign m_axis_tuser  = {out_drop_q, out_cycle_q, out_nvalid_q};
  assign m_axis_tlast  = out_last_q;

  // status to the controller
  always_comb begin
    sts_o.i_at_n      = (i_q == n);
    sts_o.e_at_total  = (e_q == edge_total_q);
    sts_o.edge_keep   = ({1'b0, e_src} < n6) && ({1'b0, e_dst} < n6);
    sts_o.edge_match  = (e_src == fifo_rdata) && ({1'b0, e_dst} < n6);
    sts_o.deg_zero    = (deg_rdata == '0);
    sts_o.deg_one     = (deg_rdata == DegW'(1));
    sts_o.fifo_empty  = (head_q == tail_q);
    sts_o.all_emitted = (head_q == n);
    sts_o.out_free    = !out_valid_q || m_axis_tready;
  end

  // the queue is never read past what was written
  assert property (@(posedge clk_i) disable iff (!rst_ni) head_q <= tail_q)
    else $error("ready queue read beyond its tail");

  // the edge count never passes the store size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_total_q <= EcW'(MAX_EDGES))
    else $error("edge count beyond store size");

  // a result is loaded only into a free or draining register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready))
    else $error("result register overwritten while held");

endmodule

// ----- tb/tb_kahn_topological_sort_top.sv -----
// testbench for the topological sort engine: directed, store-full, back-pressure and random graphs
`timescale 1ns / 1ps
module tb_kahn_topological_sort_top
  import kts_pkg::*;
();

  localparam int ClkPeriod    = 8;
  localparam int ResetCycles  = 11;
  localparam int CycleLimit   = 1_000_000;
  localparam int SettleCycles = 20;
  localparam int DrainCycles  = 50;
  localparam int HoldCycles   = 3000;
  localparam int MaxNodes     = DefMaxNodes;
  localparam int MaxEdges     = DefMaxEdges;

  // one emitted result as the engine should present it
  typedef struct packed {
    logic [NodeW-1:0] node;
    logic             valid;
    logic             cyc;
    logic             dropped;
    logic             last;
  } sort_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgW-1:0]     cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // src_node[4:0], dst_node[9:5], zero fill
  logic                s_axis_tuser;   // op
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // order_node[4:0], zero fill
  logic [OutUserW-1:0] m_axis_tuser;   // node_valid[0], cycle_found[1], edge_dropped[2]
  logic                m_axis_tlast;

  // shadow of the engine state
  logic [NodeW-1:0] stored_src [MaxEdges];
  logic [NodeW-1:0] stored_dst [MaxEdges];
  int               stored_edges;
  logic             drop_seen;
  logic [CfgW-1:0]  node_count_shadow;

  sort_result_t expected_order_q[$];
  sort_result_t order_head;

  int   error_count = 0;
  int   items_sent;
  int   cycle_count = 0;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   hold_seq = 0;
  int   hold_seen = 0;
  int   rx_hold_left = 0;
  logic input_offered;

  kahn_topological_sort_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // node count in use, clamped to 1..32
  function automatic int active_node_count();
    if (node_count_shadow > CfgW'(MaxNodes)) return MaxNodes;
    if (node_count_shadow == '0) return 1;
    return int'(node_count_shadow);
  endfunction

  // edge add: stored unless out of range or the store is full
  function automatic void record_edge(logic [NodeW-1:0] src, logic [NodeW-1:0] dst);
    int n;
    n = active_node_count();
    if (src >= n || dst >= n || stored_edges >= MaxEdges) begin
      drop_seen = 1'b1;
    end else begin
      stored_src[stored_edges] = src;
      stored_dst[stored_edges] = dst;
      stored_edges++;
    end
  endfunction

  // sort run: queue the emitted order, then the cycle marker if nodes remain
  function automatic void predict_sort_order();
    int           n;
    int           indeg [MaxNodes];
    int           ready_nodes [MaxNodes];
    int           head;
    int           tail;
    int           emitted;
    int           cur;
    int           d;
    sort_result_t r;
    n       = active_node_count();
    head    = 0;
    tail    = 0;
    emitted = 0;
    for (int i = 0; i < MaxNodes; i++) indeg[i] = 0;
    // recount over edges valid for the current node count
    for (int e = 0; e < stored_edges; e++) begin
      if (stored_src[e] < n && stored_dst[e] < n) indeg[stored_dst[e]]++;
    end
    for (int i = 0; i < n; i++) begin
      if (indeg[i] == 0 && tail < n) begin
        ready_nodes[tail] = i;
        tail++;
      end
    end
    while (head < tail) begin
      cur = ready_nodes[head];
      head++;
      emitted++;
      r.node    = NodeW'(cur);
      r.valid   = 1'b1;
      r.cyc     = 1'b0;
      r.dropped = drop_seen;
      r.last    = (emitted == n);
      expected_order_q.insert(expected_order_q.size(), r);
      // release successors in insertion order
      for (int e = 0; e < stored_edges; e++) begin
        d = stored_dst[e];
        if (stored_src[e] != cur || d >= n || indeg[d] == 0) continue;
        indeg[d]--;
        if (indeg[d] == 0 && tail < n) begin
          ready_nodes[tail] = d;
          tail++;
        end
      end
    end
    if (emitted < n) begin
      r.node    = '0;
      r.valid   = 1'b0;
      r.cyc     = 1'b1;
      r.dropped = drop_seen;
      r.last    = 1'b1;
      expected_order_q.insert(expected_order_q.size(), r);
    end
    stored_edges = 0;
    drop_seen    = 1'b0;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  // result side: random stalls plus long hold-offs on request
  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen    = hold_seq;
      rx_hold_left = HoldCycles;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_order_q.size() == 0) begin
        $error("unexpected result transaction: order_node %0d", m_axis_tdata[NodeW-1:0]);
        error_count++;
      end else begin
        order_head = expected_order_q.pop_front();
        check_field("order_node", 8'(order_head.node), 8'(m_axis_tdata[NodeW-1:0]));
        check_field("node_valid", 8'(order_head.valid), 8'(m_axis_tuser[0]));
        check_field("cycle_found", 8'(order_head.cyc), 8'(m_axis_tuser[1]));
        check_field("edge_dropped", 8'(order_head.dropped), 8'(m_axis_tuser[2]));
        check_field("last", 8'(order_head.last), 8'(m_axis_tlast));
      end
    end
  end

  // one input transaction, with random idle cycles ahead of it
  task automatic send_item(logic op, logic [NodeW-1:0] src, logic [NodeW-1:0] dst);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      if (input_offered) s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= InDataW'({dst, src});
    input_offered = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OpAddEdge) record_edge(src, dst);
    else predict_sort_order();
    items_sent++;
  endtask

  // stop offering, drain all results and wait until the engine is idle again
  task automatic settle_block();
    if (input_offered) begin
      s_axis_tvalid <= 1'b0;
      input_offered = 1'b0;
    end
    while (expected_order_q.size() != 0 || !s_axis_tready) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_node_count(logic [CfgW-1:0] value);
    settle_block();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    node_count_shadow = value;
  endtask

  // smallest graph: self loop, out-of-range drop, empty run
  task automatic test_single_node();
    write_node_count(6'd0);
    send_item(OpAddEdge, 5'd0, 5'd0);
    send_item(OpAddEdge, 5'd1, 5'd0);
    send_item(OpRunSort, 5'd0, 5'd0);
    send_item(OpRunSort, 5'd31, 5'd31);
  endtask

  // all 32 nodes, edges touching both ends of the node range
  task automatic test_full_width_order();
    write_node_count(6'd63);
    send_item(OpRunSort, 5'd0, 5'd0);
    send_item(OpAddEdge, 5'd31, 5'd0);
    send_item(OpAddEdge, 5'd0, 5'd30);
    send_item(OpAddEdge, 5'd30, 5'd1);
    send_item(OpRunSort, 5'd0, 5'd0);
  endtask

  // two-node loop with a two-node chain feeding into it
  task automatic test_cycle_detection();
    write_node_count(6'd32);
    send_item(OpAddEdge, 5'd3, 5'd4);
    send_item(OpAddEdge, 5'd4, 5'd3);
    send_item(OpAddEdge, 5'd1, 5'd2);
    send_item(OpAddEdge, 5'd2, 5'd4);
    send_item(OpRunSort, 5'd0, 5'd0);
  endtask

  // edges stored under a wide node count, run under a narrow one
  task automatic test_count_change();
    write_node_count(6'd32);
    send_item(OpAddEdge, 5'd20, 5'd5);
    send_item(OpAddEdge, 5'd2, 5'd25);
    send_item(OpAddEdge, 5'd1, 5'd3);
    send_item(OpAddEdge, 5'd7, 5'd0);
    write_node_count(6'd8);
    send_item(OpRunSort, 5'd0, 5'd0);
    send_item(OpAddEdge, 5'd8, 5'd0);
    send_item(OpAddEdge, 5'd0, 5'd7);
    send_item(OpRunSort, 5'd0, 5'd0);
  endtask

  // fill the edge store, one more edge is dropped; all edges point at node 31
  task automatic test_store_full();
    write_node_count(6'd32);
    for (int i = 0; i < MaxEdges; i++) send_item(OpAddEdge, NodeW'(i % 31), 5'd31);
    send_item(OpAddEdge, 5'd0, 5'd31);
    send_item(OpRunSort, 5'd0, 5'd0);
  endtask

  // results held back long enough for the engine to stall its input
  task automatic test_output_backpressure();
    write_node_count(6'd12);
    for (int k = 0; k < 11; k++) send_item(OpAddEdge, NodeW'(k), NodeW'(k + 1));
    hold_seq++;
    send_item(OpRunSort, 5'd0, 5'd0);
    send_item(OpAddEdge, 5'd5, 5'd2);
    send_item(OpAddEdge, 5'd2, 5'd9);
    send_item(OpAddEdge, 5'd9, 5'd5);
    send_item(OpRunSort, 5'd0, 5'd0);
  endtask

  // random graphs: mostly acyclic, some with a back edge, some noise, some count changes
  task automatic test_random_graphs(int tx_pct, int rx_pct, int item_target);
    int               first_item;
    int               n;
    int               span;
    int               kind;
    int               pick;
    int               m;
    int               a;
    int               b;
    int               tmp;
    int               perm [MaxNodes];
    logic [CfgW-1:0]  cfg_val;
    logic [NodeW-1:0] src;
    logic [NodeW-1:0] dst;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    first_item  = items_sent;
    while (items_sent - first_item < item_target) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        cfg_val = '0;
        n       = 1;
      end else if (pick == 1) begin
        cfg_val = CfgW'($urandom_range(33, 63));
        n       = MaxNodes;
      end else if (pick == 2) begin
        cfg_val = CfgW'(MaxNodes);
        n       = MaxNodes;
      end else begin
        n       = $urandom_range(2, 12);
        cfg_val = CfgW'(n);
      end
      kind = $urandom_range(0, 9);
      // count change: edges go in under a wider count first
      span = (kind == 9) ? $urandom_range(n, MaxNodes) : n;
      write_node_count((kind == 9) ? CfgW'(span) : cfg_val);
      for (int i = 0; i < span; i++) perm[i] = i;
      for (int i = span - 1; i > 0; i--) begin
        a       = $urandom_range(0, i);
        tmp     = perm[i];
        perm[i] = perm[a];
        perm[a] = tmp;
      end
      m = (span < 2) ? $urandom_range(0, 1) : $urandom_range(0, (2 * span < 24) ? 2 * span : 24);
      for (int j = 0; j < m; j++) begin
        if (kind == 8 || $urandom_range(0, 19) == 0) begin
          src = NodeW'($urandom_range(0, 31));
          dst = NodeW'($urandom_range(0, 31));
        end else if (span < 2) begin
          src = '0;
          dst = '0;
        end else begin
          a   = $urandom_range(0, span - 2);
          b   = $urandom_range(a + 1, span - 1);
          src = NodeW'(perm[a]);
          dst = NodeW'(perm[b]);
        end
        send_item(OpAddEdge, src, dst);
      end
      // back edge against the ordering closes a loop
      if ((kind == 6 || kind == 7) && span >= 2) begin
        a = $urandom_range(0, span - 2);
        b = $urandom_range(a + 1, span - 1);
        send_item(OpAddEdge, NodeW'(perm[b]), NodeW'(perm[a]));
      end
      if (kind == 9) write_node_count(cfg_val);
      send_item(OpRunSort, NodeW'($urandom_range(0, 31)), NodeW'($urandom_range(0, 31)));
    end
  endtask

  // test sequence
  initial begin
    items_sent        = 0;
    input_offered     = 1'b0;
    stored_edges      = 0;
    drop_seen         = 1'b0;
    node_count_shadow = NodeCountReset;
    tx_idle_pct       = 10;
    rx_idle_pct       = 63;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OpAddEdge;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_node();
    test_full_width_order();
    test_cycle_detection();
    test_count_change();
    test_random_graphs(10, 63, 77);
    test_random_graphs(63, 10, 77);
    test_random_graphs(0, 0, 76);
    test_store_full();
    test_output_backpressure();

    // drain and let the engine finish
    settle_block();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_order_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_order_q.size());
    end
    if (error_count == 0 && expected_order_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/kts_pkg.sv
rtl/kts_ram.sv
rtl/kts_ctrl.sv
rtl/kts_dp.sv
rtl/kahn_topological_sort_top.sv
tb/tb_kahn_topological_sort_top.sv
